### design/sbs_pkg.sv
// shared types, constants and helpers of the selective background subtraction block
package sbs_pkg;

    localparam int unsigned IDX_W      = 19;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned RATE_W     = 17;
    localparam int unsigned RATE_FRAC  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned GRAY_SUM_W = 23;
    localparam int unsigned GRAY_SHIFT = 14;

    localparam int unsigned SBS_FRAME_PIXELS = 524288;

    // luma weights, q14
    localparam logic [GRAY_SUM_W-1:0] GRAY_KB  = GRAY_SUM_W'(1868);
    localparam logic [GRAY_SUM_W-1:0] GRAY_KG  = GRAY_SUM_W'(9617);
    localparam logic [GRAY_SUM_W-1:0] GRAY_KR  = GRAY_SUM_W'(4899);
    localparam logic [GRAY_SUM_W-1:0] GRAY_RND = GRAY_SUM_W'(8192);

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

    localparam logic [PIX_W-1:0]  THR_RESET     = PIX_W'(30);
    localparam logic [RATE_W-1:0] RATE_BG_RESET = RATE_W'(1311);
    localparam logic [RATE_W-1:0] RATE_FG_RESET = RATE_W'(66);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BG   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FG   = CFG_IDX_W'(2);

    typedef enum logic {
        OP_PROCESS = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [IDX_W-1:0] pixel_index;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] load_value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index_out;
        logic             foreground;
    } t_out_word;

    // item as it moves down the pipeline once gray is known
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] gray;
        logic [PIX_W-1:0] load_value;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]  threshold;
        logic [RATE_W-1:0] rate_bg;
        logic [RATE_W-1:0] rate_fg;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] pixel_index;
        logic             foreground;
    } t_result;

    function automatic int unsigned slot_width(input int unsigned depth);
        int unsigned w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

### design/sbs_front.sv
// front stages: gray conversion and frame slot reduction over three register stages
module sbs_front import sbs_pkg::*; #(
    parameter int unsigned FRAME_PIXELS = SBS_FRAME_PIXELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  t_in_word                             i_data,
    output logic                                 o_valid,
    output t_item                                o_item,
    output logic [slot_width(FRAME_PIXELS)-1:0]  o_slot
);

    localparam int unsigned SLOT_W = slot_width(FRAME_PIXELS);
    localparam int unsigned LOG_F  = $clog2(FRAME_PIXELS);
    localparam int unsigned SHIFT  = IDX_W + LOG_F;
    localparam int unsigned M_W    = IDX_W + 1;
    localparam int unsigned PROD_W = IDX_W + M_W;
    localparam int unsigned MOD_W  = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;

    // floor(2^SHIFT / F): the estimated quotient is exact or one low
    localparam logic [63:0]      M_FULL  = (64'd1 << SHIFT) / 64'(FRAME_PIXELS);
    localparam logic [M_W-1:0]   M_RECIP = M_FULL[M_W-1:0];
    localparam logic [IDX_W-1:0] F_LO    = IDX_W'(FRAME_PIXELS);
    localparam logic [MOD_W-1:0] F_MOD   = MOD_W'(FRAME_PIXELS);

    logic                  r1_valid, r2_valid, r3_valid;
    t_item                 r1_item, r2_item, r3_item;
    logic [IDX_W-1:0]      r1_q;
    logic [IDX_W-1:0]      r2_rem;
    logic [SLOT_W-1:0]     r3_slot;

    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PROD_W-1:0]     q_prod;
    logic [PROD_W-1:0]     q_shift;
    logic [2*IDX_W-1:0]    qf_prod;
    logic [MOD_W-1:0]      rem_ext;
    logic [MOD_W-1:0]      slot_full;
    t_item                 n1_item;

    always_comb begin
        gray_sum = GRAY_KB * GRAY_SUM_W'(i_data.blue)
                 + GRAY_KG * GRAY_SUM_W'(i_data.green)
                 + GRAY_KR * GRAY_SUM_W'(i_data.red)
                 + GRAY_RND;
        n1_item.op         = i_data.operation;
        n1_item.idx        = i_data.pixel_index;
        n1_item.gray       = gray_sum[GRAY_SHIFT +: PIX_W];
        n1_item.load_value = i_data.load_value;
        q_prod  = PROD_W'(i_data.pixel_index) * PROD_W'(M_RECIP);
        q_shift = q_prod >> SHIFT;
    end

    always_comb begin
        qf_prod = (2*IDX_W)'(r1_q) * (2*IDX_W)'(F_LO);
    end

    always_comb begin
        rem_ext   = MOD_W'(r2_rem);
        slot_full = (rem_ext >= F_MOD) ? (rem_ext - F_MOD) : rem_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= n1_item;
            r1_q    <= q_shift[IDX_W-1:0];
            r2_item <= r1_item;
            // true remainder fits the index width, so the product wraps harmlessly
            r2_rem  <= r1_item.idx - qf_prod[IDX_W-1:0];
            r3_item <= r2_item;
            r3_slot <= slot_full[SLOT_W-1:0];
        end
    end

    assign o_valid = r3_valid;
    assign o_item  = r3_item;
    assign o_slot  = r3_slot;

endmodule

### design/sbs_update.sv
// background memory, foreground decision and running-average write-back
module sbs_update import sbs_pkg::*; #(
    parameter int unsigned FRAME_PIXELS = SBS_FRAME_PIXELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  t_cfg                                 i_cfg,
    input  logic                                 i_valid,
    input  t_item                                i_item,
    input  logic [slot_width(FRAME_PIXELS)-1:0]  i_slot,
    output t_result                              o_result
);

    localparam int unsigned SLOT_W = slot_width(FRAME_PIXELS);
    localparam int unsigned PROD_W = RATE_W + PIX_W + 1;

    logic [PIX_W-1:0]  mem [FRAME_PIXELS];

    logic              r4_valid;
    t_item             r4_item;
    logic [SLOT_W-1:0] r4_slot;
    logic [PIX_W-1:0]  r_rd_data;
    logic              r_fwd;
    logic [PIX_W-1:0]  r_fwd_data;

    logic [PIX_W-1:0]         bg;
    logic signed [PIX_W:0]    diff_s;
    logic [PIX_W:0]           abs_full;
    logic [PIX_W-1:0]         abs_d;
    logic                     fg;
    logic signed [PROD_W-1:0] prod_bg;
    logic signed [PROD_W-1:0] prod_fg;
    logic [PIX_W-1:0]         new_bg;
    logic [PIX_W-1:0]         new_fg;
    logic [PIX_W-1:0]         wr_data;

    // the word ahead writes on the same edge this one reads, so take its value
    always_comb begin
        bg       = r_fwd ? r_fwd_data : r_rd_data;
        diff_s   = $signed({1'b0, r4_item.gray}) - $signed({1'b0, bg});
        abs_full = diff_s[PIX_W] ? (PIX_W+1)'(-diff_s) : (PIX_W+1)'(diff_s);
        abs_d    = abs_full[PIX_W-1:0];
        fg       = abs_d > i_cfg.threshold;
        // bg + floor(a * (gray - bg) / 2^16); both candidates in parallel
        prod_bg  = $signed({1'b0, i_cfg.rate_bg}) * diff_s;
        prod_fg  = $signed({1'b0, i_cfg.rate_fg}) * diff_s;
        new_bg   = bg + prod_bg[RATE_FRAC +: PIX_W];
        new_fg   = bg + prod_fg[RATE_FRAC +: PIX_W];
        unique case (r4_item.op)
            OP_LOAD:    wr_data = r4_item.load_value;
            OP_PROCESS: wr_data = fg ? new_fg : new_bg;
            default:    wr_data = r4_item.load_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= mem[i_slot];
            if (r4_valid) begin
                mem[r4_slot] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r_fwd    <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r_fwd    <= r4_valid && (i_slot == r4_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_item    <= i_item;
            r4_slot    <= i_slot;
            r_fwd_data <= wr_data;
        end
    end

    always_comb begin
        o_result.valid       = r4_valid && (r4_item.op == OP_PROCESS);
        o_result.pixel_index = r4_item.idx;
        o_result.foreground  = fg;
    end

`ifndef SYNTHESIS
    // running average never leaves the span between old background and gray
    a_avg_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r4_valid && r4_item.op == OP_PROCESS) |->
        ((wr_data >= bg && wr_data <= r4_item.gray) ||
         (wr_data <= bg && wr_data >= r4_item.gray)))
        else $error("background update outside old value and gray");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_rd_data))
        else $error("memory read data changed during stall");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r4_valid && i_slot == r4_slot) |=> (r_fwd && r_fwd_data == $past(wr_data)))
        else $error("same-slot word ahead not forwarded");
`endif

endmodule

### design/selective_background_subtraction_top.sv
// top level: configuration registers, pipeline control and output register
// path: an accepted pixel passes registers r1, r2, r3 and r4, then the output register
// throughput: one word per cycle unless stalled; loads, pixels, same-slot neighbors alike
// stall: the pipeline holds only while a pixel result waits behind an untaken output word
// reset: clears pipeline valids and sets threshold 30, rates 1311 and 66
// reset: background memory uncleared; user reads entries only after a load, unenforced
module selective_background_subtraction_top import sbs_pkg::*; #(
    parameter int unsigned FRAME_PIXELS = SBS_FRAME_PIXELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned SLOT_W = slot_width(FRAME_PIXELS);

    t_cfg              r_cfg;
    logic              r_out_valid;
    t_out_word         r_out_data;

    logic              en;
    logic              out_free;
    logic              front_valid;
    t_item             front_item;
    logic [SLOT_W-1:0] front_slot;
    t_result           res;
    logic [RATE_W-1:0] rate_sat;

    // rates above one saturate
    assign rate_sat = i_cfg_data[RATE_W-1] ? RATE_ONE : i_cfg_data[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THR_RESET;
            r_cfg.rate_bg   <= RATE_BG_RESET;
            r_cfg.rate_fg   <= RATE_FG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[PIX_W-1:0];
                CFG_RATE_BG:   r_cfg.rate_bg   <= rate_sat;
                CFG_RATE_FG:   r_cfg.rate_fg   <= rate_sat;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // only a pixel result blocked at the output holds the pipeline
    assign out_free   = !r_out_valid || i_out_ready;
    assign en         = out_free || !res.valid;
    assign o_in_ready = en;

    sbs_front #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (front_valid),
        .o_item  (front_item),
        .o_slot  (front_slot)
    );

    sbs_update #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_valid  (front_valid),
        .i_item   (front_item),
        .i_slot   (front_slot),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data.pixel_index_out <= res.pixel_index;
            r_out_data.foreground      <= res.foreground;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> (r_out_valid && !i_out_ready && res.valid))
        else $error("pipeline stalled without a blocked result");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(res.valid))
        else $error("output word raised without a pixel result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("output word changed while waiting");
`endif

endmodule
